[rtl/cpba_pkg.sv]
// shared constants, types and the page range mask function of the page allocator
package cpba_pkg;

	localparam int MAX_PAGES = 65536;
	localparam int PI_W      = $clog2(MAX_PAGES);
	localparam int PN_W      = PI_W + 1;
	localparam int WORD_W    = 64;
	localparam int WBIT_W    = $clog2(WORD_W);
	localparam int WORDS     = MAX_PAGES / WORD_W;
	localparam int WADDR_W   = $clog2(WORDS);
	localparam int GRP_W     = 8;
	localparam int GBIT_W    = $clog2(GRP_W);
	localparam int SUB_W     = WBIT_W - GBIT_W;
	localparam int NEED_W    = 21;
	localparam int REG_W     = 17;
	localparam int BASE_W    = 28;
	localparam int PAGE_SH   = 12;

	localparam logic [PN_W-1:0]    LIM_MAX  = PN_W'(MAX_PAGES);
	localparam logic [REG_W-1:0]   PCNT_RST = REG_W'(65536);
	localparam logic [REG_W-1:0]   RSV_RST  = REG_W'(1024);
	localparam logic [SUB_W-1:0]   SUB_LAST = {SUB_W{1'b1}};
	localparam logic [WADDR_W-1:0] WORD_LAST = {WADDR_W{1'b1}};

	// request codes
	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_INIT  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// configuration register indexes
	localparam logic CFG_PAGE_COUNT = 1'b0;
	localparam logic CFG_RESERVED   = 1'b1;

	// state handed back by the run evaluator for one group of bits
	typedef struct packed {
		logic            found;
		logic [PN_W-1:0] run;
		logic [PI_W-1:0] start;
	} run_res_t;

	// bits of word widx whose page number lies in [lo, hi)
	function automatic logic [WORD_W-1:0] range_mask(
		input logic [WADDR_W-1:0] widx,
		input logic [PN_W-1:0]    lo,
		input logic [PN_W-1:0]    hi
	);
		logic [PN_W-1:0]   p;
		logic [WORD_W-1:0] m;
		m = '0;
		for (int b = 0; b < WORD_W; b++) begin
			p    = PN_W'({widx, WBIT_W'(b)});
			m[b] = (p >= lo) && (p < hi);
		end
		return m;
	endfunction

endpackage

[rtl/cpba_map_ram.sv]
// page usage map storage, one write port and one registered read port
module cpba_map_ram
	import cpba_pkg::*;
(
	input  logic               clk,
	input  logic               wr_en,
	input  logic [WADDR_W-1:0] wr_addr,
	input  logic [WORD_W-1:0]  wr_data,
	input  logic [WADDR_W-1:0] rd_addr,
	output logic [WORD_W-1:0]  rd_data
);

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORD_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/cpba_run_unit.sv]
// free run evaluator over one group of page bits, lowest page first
module cpba_run_unit
	import cpba_pkg::*;
(
	input  logic [GRP_W-1:0]  used,
	input  logic [PI_W-1:0]   grp_base,
	input  logic [PN_W-1:0]   run_in,
	input  logic [PI_W-1:0]   start_in,
	input  logic [NEED_W-1:0] need,
	output run_res_t          res
);

	logic            fnd;
	logic [PN_W-1:0] run;
	logic [PI_W-1:0] st;

	// walk the group, extending or breaking the current run
	always_comb begin
		fnd = 1'b0;
		run = run_in;
		st  = start_in;
		for (int i = 0; i < GRP_W; i++) begin
			if (!fnd) begin
				if (!used[i]) begin
					if (run == '0) begin
						st = {grp_base[PI_W-1:GBIT_W], GBIT_W'(i)};
					end
					run = run + PN_W'(1);
					if (NEED_W'(run) >= need) begin
						fnd = 1'b1;
					end
				end else begin
					run = '0;
				end
			end
		end
		res.found = fnd;
		res.run   = run;
		res.start = st;
	end

endmodule

[rtl/contiguous_page_bitmap_allocator.sv]
// first-fit contiguous page allocator over a one-bit-per-page usage map
//
// Requests enter on start with action, size_bytes and address; one is taken
// when start is high and busy is low. Each request gives one result: done is
// high for one cycle with ok and base_address valid, and the receiver has no
// way to hold it off. Configuration writes (cfg_valid/cfg_ready, cfg_index 0
// page_count, 1 reserved_pages) are always taken; they are meant for idle time.
// The map sits in a 1024 x 64 memory with one registered read port, which
// sets the pace: an allocate scan reads each word, takes an all-free or
// all-used word whole and walks a mixed word one group of 8 bits at a time,
// then marks the pages it found by reading and rewriting each word; a free
// reads and rewrites each word it touches; init rewrites all 1024 words.
// Every request also passes a setup state and a result state. Only one
// request is in flight at a time. After reset the block clears all 1024 map
// words with busy high; page_count resets to 65536 and reserved_pages to 1024.
module contiguous_page_bitmap_allocator
	import cpba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        action,
	input  logic [31:0]       size_bytes,
	input  logic [31:0]       address,
	output logic              done,
	output logic              ok,
	output logic [BASE_W-1:0] base_address,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [REG_W-1:0]  cfg_data
);

	typedef enum logic [10:0] {
		S_CLEAR   = 11'b000_0000_0001,
		S_IDLE    = 11'b000_0000_0010,
		S_SETUP   = 11'b000_0000_0100,
		S_SC_RD   = 11'b000_0000_1000,
		S_SC_EVAL = 11'b000_0001_0000,
		S_SC_BIT  = 11'b000_0010_0000,
		S_MK_INIT = 11'b000_0100_0000,
		S_MK_RD   = 11'b000_1000_0000,
		S_MK_WR   = 11'b001_0000_0000,
		S_IN_WR   = 11'b010_0000_0000,
		S_DONE    = 11'b100_0000_0000
	} state_t;

	state_t              state_q;
	logic [REG_W-1:0]    page_count_q;
	logic [REG_W-1:0]    reserved_q;
	logic [WADDR_W-1:0]  word_q;
	logic [SUB_W-1:0]    sub_q;
	action_t             act_q;
	logic [31:0]         addr_q;
	logic [NEED_W-1:0]   pages_q;
	logic [NEED_W-1:0]   need_q;
	logic [PN_W-1:0]     lim_q;
	logic [PN_W-1:0]     run_q;
	logic [PI_W-1:0]     start_q;
	logic [PN_W-1:0]     lo_q;
	logic [PN_W-1:0]     hi_q;
	logic                set_q;
	logic [WORD_W-1:0]   eff_q;
	logic                ok_q;
	logic [BASE_W-1:0]   base_q;

	logic [PN_W-1:0]     lim_w;
	logic [PN_W-1:0]     rsv_w;
	logic [WORD_W-1:0]   rd_data;
	logic [WORD_W-1:0]   wr_data;
	logic                wr_en;
	logic [WORD_W-1:0]   mask_w;
	logic [WORD_W-1:0]   vmask_w;
	logic [WORD_W-1:0]   eff_w;
	logic [WADDR_W-1:0]  last_w;
	logic [WADDR_W-1:0]  hi_word_w;
	logic [PI_W-1:0]     word_base_w;
	logic [PN_W-1:0]     run64_w;
	logic [GRP_W-1:0]    grp_w;
	run_res_t            grp_res;
	logic [19:0]         fstart_w;
	logic [21:0]         fend_w;
	logic [PN_W-1:0]     fend_c_w;
	logic                fempty_w;
	logic                accept;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign done      = (state_q == S_DONE);
	assign ok        = ok_q;
	assign base_address = base_q;
	assign cfg_ready = 1'b1;

	// working page limit and clamped reserved count
	assign lim_w = (PN_W'(page_count_q) > LIM_MAX) ? LIM_MAX : PN_W'(page_count_q);
	assign rsv_w = (PN_W'(reserved_q) > lim_q) ? lim_q : PN_W'(reserved_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= PCNT_RST;
			reserved_q   <= RSV_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PAGE_COUNT: page_count_q <= cfg_data;
				CFG_RESERVED:   reserved_q   <= cfg_data;
				default:        page_count_q <= page_count_q;
			endcase
		end
	end

	// map memory
	cpba_map_ram u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (word_q),
		.wr_data (wr_data),
		.rd_addr (word_q),
		.rd_data (rd_data)
	);

	// masks for the current word
	assign mask_w      = range_mask(word_q, lo_q, hi_q);
	assign vmask_w     = range_mask(word_q, '0, lim_q);
	assign eff_w       = rd_data | ~vmask_w;
	assign last_w      = WADDR_W'((lim_q - PN_W'(1)) >> WBIT_W);
	assign hi_word_w   = WADDR_W'((hi_q - PN_W'(1)) >> WBIT_W);
	assign word_base_w = {word_q, WBIT_W'(0)};
	assign run64_w     = run_q + PN_W'(WORD_W);

	// memory write selection
	always_comb begin
		wr_en   = 1'b0;
		wr_data = '0;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_IN_WR: begin
				wr_en   = 1'b1;
				wr_data = mask_w;
			end
			S_MK_WR: begin
				wr_en   = 1'b1;
				wr_data = set_q ? (rd_data | mask_w) : (rd_data & ~mask_w);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// one group of the current word through the run evaluator
	assign grp_w = eff_q[sub_q*GRP_W +: GRP_W];

	cpba_run_unit u_run (
		.used     (grp_w),
		.grp_base ({word_q, sub_q, GBIT_W'(0)}),
		.run_in   (run_q),
		.start_in (start_q),
		.need     (need_q),
		.res      (grp_res)
	);

	// free range set up
	assign fstart_w = addr_q[31:PAGE_SH];
	assign fend_w   = 22'(fstart_w) + 22'(pages_q);
	assign fend_c_w = (fend_w > 22'(lim_q)) ? lim_q : fend_w[PN_W-1:0];
	assign fempty_w = (addr_q == '0) || (22'(fstart_w) >= 22'(fend_c_w));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			word_q  <= '0;
			sub_q   <= '0;
			ok_q    <= 1'b0;
			base_q  <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					word_q <= word_q + WADDR_W'(1);
					if (word_q == WORD_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						act_q   <= action_t'(action);
						addr_q  <= address;
						pages_q <= NEED_W'(({1'b0, size_bytes} + 33'd4095) >> PAGE_SH);
						lim_q   <= lim_w;
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					ok_q   <= 1'b1;
					base_q <= '0;
					case (act_q)
						ACT_ALLOC: begin
							need_q  <= (pages_q == '0) ? NEED_W'(1) : pages_q;
							run_q   <= '0;
							start_q <= '0;
							word_q  <= '0;
							if (lim_q == '0) begin
								ok_q    <= 1'b0;
								state_q <= S_DONE;
							end else begin
								state_q <= S_SC_RD;
							end
						end
						ACT_FREE: begin
							lo_q   <= fstart_w[PN_W-1:0];
							hi_q   <= fend_c_w;
							word_q <= fstart_w[PI_W-1:WBIT_W];
							set_q  <= 1'b0;
							state_q <= fempty_w ? S_DONE : S_MK_RD;
						end
						ACT_INIT: begin
							lo_q    <= '0;
							hi_q    <= rsv_w;
							word_q  <= '0;
							state_q <= S_IN_WR;
						end
						default: begin
							ok_q    <= 1'b0;
							state_q <= S_DONE;
						end
					endcase
				end
				S_SC_RD: begin
					state_q <= S_SC_EVAL;
				end
				S_SC_EVAL: begin
					if (eff_w == '0) begin
						// whole word free
						if (run_q == '0) begin
							start_q <= word_base_w;
						end
						if (NEED_W'(run64_w) >= need_q) begin
							lo_q    <= PN_W'((run_q == '0) ? word_base_w : start_q);
							state_q <= S_MK_INIT;
						end else begin
							run_q <= run64_w;
							if (word_q == last_w) begin
								ok_q    <= 1'b0;
								state_q <= S_DONE;
							end else begin
								word_q  <= word_q + WADDR_W'(1);
								state_q <= S_SC_RD;
							end
						end
					end else if (&eff_w) begin
						// whole word used
						run_q <= '0;
						if (word_q == last_w) begin
							ok_q    <= 1'b0;
							state_q <= S_DONE;
						end else begin
							word_q  <= word_q + WADDR_W'(1);
							state_q <= S_SC_RD;
						end
					end else begin
						eff_q   <= eff_w;
						sub_q   <= '0;
						state_q <= S_SC_BIT;
					end
				end
				S_SC_BIT: begin
					if (grp_res.found) begin
						lo_q    <= PN_W'(grp_res.start);
						state_q <= S_MK_INIT;
					end else begin
						run_q   <= grp_res.run;
						start_q <= grp_res.start;
						sub_q   <= sub_q + SUB_W'(1);
						if (sub_q == SUB_LAST) begin
							if (word_q == last_w) begin
								ok_q    <= 1'b0;
								state_q <= S_DONE;
							end else begin
								word_q  <= word_q + WADDR_W'(1);
								state_q <= S_SC_RD;
							end
						end
					end
				end
				S_MK_INIT: begin
					hi_q    <= lo_q + PN_W'(need_q);
					word_q  <= lo_q[PI_W-1:WBIT_W];
					set_q   <= 1'b1;
					base_q  <= {lo_q[PI_W-1:0], PAGE_SH'(0)};
					state_q <= S_MK_RD;
				end
				S_MK_RD: begin
					state_q <= S_MK_WR;
				end
				S_MK_WR: begin
					if (word_q == hi_word_w) begin
						state_q <= S_DONE;
					end else begin
						word_q  <= word_q + WADDR_W'(1);
						state_q <= S_MK_RD;
					end
				end
				S_IN_WR: begin
					word_q <= word_q + WADDR_W'(1);
					if (word_q == WORD_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a failed request never carries an address
	a_fail_no_base: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> base_address == '0)
		else $error("failed request returned a nonzero base address");

	// an accepted request keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !done)
		else $error("request accepted but block not busy");

	// the map is never written while the block is idle
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !wr_en)
		else $error("map written while idle");

	// an allocated base lies below the working page limit
	a_base_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done && ok && base_address != '0 |-> PN_W'(base_address[BASE_W-1:PAGE_SH]) < lim_q)
		else $error("allocated base beyond the page limit");

endmodule
